// File: rtl/core/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Types, codes, reset values and CRC helpers for the packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_SIZE = 4'b0010,
        PH_BODY = 4'b0100,
        PH_CRC  = 4'b1000
    } phase_t;

    localparam logic [2:0] REG_ID_MM       = 3'd0;
    localparam logic [2:0] REG_ID_ASYNC    = 3'd1;
    localparam logic [2:0] REG_ID_ERROR    = 3'd2;
    localparam logic [2:0] REG_ID_PRINT    = 3'd3;
    localparam logic [2:0] REG_CRC_POLY    = 3'd4;
    localparam logic [2:0] REG_CRC_INIT    = 3'd5;
    localparam logic [2:0] REG_CRC_XOR     = 3'd6;
    localparam logic [2:0] REG_CRC_REFLECT = 3'd7;

    localparam logic [31:0] RST_ID_MM       = 32'd1;
    localparam logic [31:0] RST_ID_ASYNC    = 32'd2;
    localparam logic [31:0] RST_ID_ERROR    = 32'd3;
    localparam logic [31:0] RST_ID_PRINT    = 32'd4;
    localparam logic [31:0] RST_CRC_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] RST_CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_CRC_XOR     = 32'hFFFF_FFFF;
    localparam logic [1:0]  RST_CRC_REFLECT = 2'd3;

    localparam logic [1:0] TYPE_MM    = 2'd0;
    localparam logic [1:0] TYPE_ASYNC = 2'd1;
    localparam logic [1:0] TYPE_ERROR = 2'd2;
    localparam logic [1:0] TYPE_PRINT = 2'd3;

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_CRC_ERR   = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [31:0] SIZE_MIN_MM    = 32'd8;
    localparam logic [31:0] SIZE_MIN_ASYNC = 32'd4;
    localparam logic [31:0] SIZE_MIN_ERROR = 32'd4;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [31:0] mirror32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31-i];
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_feed(
        input logic [31:0] rem,
        input logic [7:0]  data,
        input logic [31:0] poly,
        input logic        refl_in
    );
        logic [31:0] r;
        logic [7:0]  d;
        d = refl_in ? mirror8(data) : data;
        r = rem ^ {d, 24'd0};
        for (int i = 0; i < 8; i++) begin
            r = r[31] ? ({r[30:0], 1'b0} ^ poly) : {r[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/crc_checked_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer
// Byte stream deframer: hunts for one of four identifier words, reads a
// little-endian size, forwards the body bytes tagged with their package type
// and reports a CRC-32 or size-too-small status after the trailing four CRC
// bytes. A byte can be accepted in each cycle, and a result leaves through
// a single output register that does not stall the input unless it is full
// and not being taken. The CRC engine processes one accepted byte per cycle
// over a four-byte delay line, so the identifier, size and body bytes are
// folded into the remainder during the size, body and CRC phases, and the
// comparison completes with the last CRC byte. Configure only while idle.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_result_kind,
    output logic [1:0]                        m_package_type,
    output logic [7:0]                        m_body_byte,
    output logic [1:0]                        m_status,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cpd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [cpd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [cpd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [31:0] id_mm_reg, id_async_reg, id_error_reg, id_print_reg;
    logic [31:0] crc_poly_reg, crc_init_reg, crc_xor_reg;
    logic [1:0]  crc_reflect_reg;
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    cpd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [31:0] delay_reg, delay_next;
    logic [1:0]  type_reg, type_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] recv_reg, recv_next;

    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    logic [1:0]  ptype_reg, ptype_next;
    logic [7:0]  body_reg, body_next;
    logic [1:0]  status_reg, status_next;

    logic        accept;
    logic [31:0] win_shift;
    logic [31:0] crc_fed;
    logic [31:0] recv_full;
    logic [31:0] crc_final;
    logic [31:0] size_min;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[cpd_pkg::CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            cpd_pkg::REG_ID_MM:       prdata = id_mm_reg;
            cpd_pkg::REG_ID_ASYNC:    prdata = id_async_reg;
            cpd_pkg::REG_ID_ERROR:    prdata = id_error_reg;
            cpd_pkg::REG_ID_PRINT:    prdata = id_print_reg;
            cpd_pkg::REG_CRC_POLY:    prdata = crc_poly_reg;
            cpd_pkg::REG_CRC_INIT:    prdata = crc_init_reg;
            cpd_pkg::REG_CRC_XOR:     prdata = crc_xor_reg;
            cpd_pkg::REG_CRC_REFLECT: prdata = {30'd0, crc_reflect_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_mm_reg       <= cpd_pkg::RST_ID_MM;
            id_async_reg    <= cpd_pkg::RST_ID_ASYNC;
            id_error_reg    <= cpd_pkg::RST_ID_ERROR;
            id_print_reg    <= cpd_pkg::RST_ID_PRINT;
            crc_poly_reg    <= cpd_pkg::RST_CRC_POLY;
            crc_init_reg    <= cpd_pkg::RST_CRC_INIT;
            crc_xor_reg     <= cpd_pkg::RST_CRC_XOR;
            crc_reflect_reg <= cpd_pkg::RST_CRC_REFLECT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                cpd_pkg::REG_ID_MM:       id_mm_reg       <= pwdata;
                cpd_pkg::REG_ID_ASYNC:    id_async_reg    <= pwdata;
                cpd_pkg::REG_ID_ERROR:    id_error_reg    <= pwdata;
                cpd_pkg::REG_ID_PRINT:    id_print_reg    <= pwdata;
                cpd_pkg::REG_CRC_POLY:    crc_poly_reg    <= pwdata;
                cpd_pkg::REG_CRC_INIT:    crc_init_reg    <= pwdata;
                cpd_pkg::REG_CRC_XOR:     crc_xor_reg     <= pwdata;
                cpd_pkg::REG_CRC_REFLECT: crc_reflect_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // datapath
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign win_shift = {s_rx_byte, window_reg[31:8]};
    assign crc_fed   = cpd_pkg::crc_feed(crc_reg, delay_reg[7:0], crc_poly_reg,
                                         crc_reflect_reg[0]);
    assign recv_full = {s_rx_byte, recv_reg[31:8]};
    assign crc_final = (crc_reflect_reg[1] ? cpd_pkg::mirror32(crc_fed) : crc_fed)
                       ^ crc_xor_reg;

    always_comb begin
        unique case (type_reg)
            cpd_pkg::TYPE_MM:    size_min = cpd_pkg::SIZE_MIN_MM;
            cpd_pkg::TYPE_ASYNC: size_min = cpd_pkg::SIZE_MIN_ASYNC;
            cpd_pkg::TYPE_ERROR: size_min = cpd_pkg::SIZE_MIN_ERROR;
            default:             size_min = '0;
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        delay_next   = delay_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        recv_next    = recv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        ptype_next   = ptype_reg;
        body_next    = body_reg;
        status_next  = status_reg;

        if (accept) begin
            unique case (phase_reg)
                cpd_pkg::PH_HUNT: begin
                    window_next = win_shift;
                    priority if (win_shift == id_mm_reg) begin
                        type_next  = cpd_pkg::TYPE_MM;
                        phase_next = cpd_pkg::PH_SIZE;
                    end else if (win_shift == id_async_reg) begin
                        type_next  = cpd_pkg::TYPE_ASYNC;
                        phase_next = cpd_pkg::PH_SIZE;
                    end else if (win_shift == id_error_reg) begin
                        type_next  = cpd_pkg::TYPE_ERROR;
                        phase_next = cpd_pkg::PH_SIZE;
                    end else if (win_shift == id_print_reg) begin
                        type_next  = cpd_pkg::TYPE_PRINT;
                        phase_next = cpd_pkg::PH_SIZE;
                    end else begin
                        phase_next = cpd_pkg::PH_HUNT;
                    end
                    if (phase_next == cpd_pkg::PH_SIZE) begin
                        crc_next    = crc_init_reg;
                        delay_next  = win_shift;
                        length_next = '0;
                        count_next  = '0;
                    end
                end
                cpd_pkg::PH_SIZE: begin
                    crc_next    = crc_fed;
                    delay_next  = {s_rx_byte, delay_reg[31:8]};
                    length_next = {s_rx_byte, length_reg[31:8]};
                    if (count_reg[1:0] == 2'd3) begin
                        count_next = '0;
                        phase_next = (length_next == '0) ? cpd_pkg::PH_CRC
                                                         : cpd_pkg::PH_BODY;
                    end else begin
                        count_next = count_reg + 32'd1;
                    end
                end
                cpd_pkg::PH_BODY: begin
                    crc_next     = crc_fed;
                    delay_next   = {s_rx_byte, delay_reg[31:8]};
                    if (count_reg + 32'd1 >= length_reg) begin
                        count_next = '0;
                        phase_next = cpd_pkg::PH_CRC;
                    end else begin
                        count_next = count_reg + 32'd1;
                    end
                    m_valid_next = 1'b1;
                    kind_next    = cpd_pkg::KIND_BODY;
                    ptype_next   = type_reg;
                    body_next    = s_rx_byte;
                    status_next  = cpd_pkg::ST_VALID;
                end
                cpd_pkg::PH_CRC: begin
                    crc_next   = crc_fed;
                    delay_next = {8'd0, delay_reg[31:8]};
                    recv_next  = recv_full;
                    if (count_reg[1:0] == 2'd3) begin
                        count_next   = '0;
                        phase_next   = cpd_pkg::PH_HUNT;
                        m_valid_next = 1'b1;
                        kind_next    = cpd_pkg::KIND_STATUS;
                        ptype_next   = type_reg;
                        body_next    = '0;
                        if (length_reg < size_min) begin
                            status_next = cpd_pkg::ST_TOO_SMALL;
                        end else if (crc_final == recv_full) begin
                            status_next = cpd_pkg::ST_VALID;
                        end else begin
                            status_next = cpd_pkg::ST_CRC_ERR;
                        end
                    end else begin
                        count_next = count_reg + 32'd1;
                    end
                end
                default: begin
                    phase_next = cpd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= cpd_pkg::PH_HUNT;
            window_reg  <= '0;
            delay_reg   <= '0;
            type_reg    <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            crc_reg     <= '0;
            recv_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            delay_reg   <= delay_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            recv_reg    <= recv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        ptype_reg  <= ptype_next;
        body_reg   <= body_next;
        status_reg <= status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_package_type = ptype_reg;
    assign m_body_byte    = body_reg;
    assign m_status       = status_reg;

endmodule
